FILE: rtl/core/bdm_pkg.sv
// Shared types, constants and the kernel clamp helper for the 5x5 Bayer demosaic.
package bdm_pkg;

    localparam int PIX_W        = 16;
    localparam int SIZE_W       = 11;
    localparam int MAX_COLS     = 1024;
    localparam int BORDER       = 2;
    localparam int WINDOW_LINES = 5;
    localparam int LINE_SLOTS   = WINDOW_LINES - 1;
    localparam int SLOT_W       = $clog2(LINE_SLOTS);
    localparam int COL_W        = $clog2(MAX_COLS);
    localparam int SIZE_MIN     = 5;
    localparam int SIZE_RESET   = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam int FIRST_EMIT   = 2 * BORDER;
    localparam int ACC_W        = PIX_W + 5;
    localparam int TDATA_OUT_W  = 3 * PIX_W;

    localparam logic [2:0] SH_THREE = 3'd3;
    localparam logic [2:0] SH_FOUR  = 3'd4;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [COL_W-1:0] pos_t;
    typedef pix_t [WINDOW_LINES-1:0][WINDOW_LINES-1:0] win_t;

    localparam pix_t PIX_MAX = {PIX_W{1'b1}};

    // Bayer phase of the site at the window centre
    typedef struct packed {
        logic row_odd;
        logic col_odd;
    } site_t;

    // (pos - neg) >> sh, clamped to the pixel range
    function automatic pix_t clamp_shift(input acc_t pos, input acc_t neg,
                                         input logic [2:0] sh);
        acc_t v;
        pix_t res;
        v = (pos - neg) >> sh;
        if (pos < neg) begin
            res = '0;
        end else if (v > acc_t'(PIX_MAX)) begin
            res = PIX_MAX;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/bdm_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
module bdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bdm_kernel.sv
// Gradient-corrected 5x5 kernels and per-phase colour selection.
module bdm_kernel (
    input  bdm_pkg::win_t  win,
    input  bdm_pkg::site_t site,
    output bdm_pkg::pix_t  red,
    output bdm_pkg::pix_t  green,
    output bdm_pkg::pix_t  blue
);

    bdm_pkg::acc_t ctr, n1, s1, w1, e1, n2, s2, w2, e2, dg, far;
    bdm_pkg::pix_t g_int, x_int, horiz, vert;

    assign ctr = bdm_pkg::acc_t'(win[2][2]);
    assign n1  = bdm_pkg::acc_t'(win[1][2]);
    assign s1  = bdm_pkg::acc_t'(win[3][2]);
    assign w1  = bdm_pkg::acc_t'(win[2][1]);
    assign e1  = bdm_pkg::acc_t'(win[2][3]);
    assign n2  = bdm_pkg::acc_t'(win[0][2]);
    assign s2  = bdm_pkg::acc_t'(win[4][2]);
    assign w2  = bdm_pkg::acc_t'(win[2][0]);
    assign e2  = bdm_pkg::acc_t'(win[2][4]);
    assign dg  = bdm_pkg::acc_t'(win[1][1]) + bdm_pkg::acc_t'(win[1][3])
               + bdm_pkg::acc_t'(win[3][1]) + bdm_pkg::acc_t'(win[3][3]);
    assign far = n2 + s2 + w2 + e2;

    // G at R/B
    assign g_int = bdm_pkg::clamp_shift((ctr << 2) + ((n1 + s1 + w1 + e1) << 1),
                                        far, bdm_pkg::SH_THREE);
    // R at B / B at R, 1/16 form
    assign x_int = bdm_pkg::clamp_shift(((ctr << 2) + (ctr << 1) + (dg << 1)) << 1,
                                        (far << 1) + far, bdm_pkg::SH_FOUR);
    // row colour at G
    assign horiz = bdm_pkg::clamp_shift(((n2 + s2) >> 1) + (ctr << 2) + ctr
                                        + ((w1 + e1) << 2),
                                        dg + w2 + e2, bdm_pkg::SH_THREE);
    // column colour at G
    assign vert  = bdm_pkg::clamp_shift(((w2 + e2) >> 1) + (ctr << 2) + ctr
                                        + ((n1 + s1) << 2),
                                        dg + n2 + s2, bdm_pkg::SH_THREE);

    always_comb begin
        if (!site.row_odd && !site.col_odd) begin
            red   = win[2][2];
            green = g_int;
            blue  = x_int;
        end else if (!site.row_odd) begin
            red   = horiz;
            green = win[2][2];
            blue  = vert;
        end else if (!site.col_odd) begin
            red   = vert;
            green = win[2][2];
            blue  = horiz;
        end else begin
            red   = x_int;
            green = g_int;
            blue  = win[2][2];
        end
    end

endmodule

FILE: rtl/core/bayer_demosaic_5x5_core.sv
// Top level of the 5x5 gradient-corrected RGGB demosaic core.
//
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata = raw_pixel
// m_        out  m_tvalid/m_tready   m_tdata = red, green, blue; m_tlast = row_end;
//                                    m_tuser = frame_end
// cfg_      in   cfg_valid/cfg_ready cfg_data = image_size (clamped to 5..MAX_COLS)
//
// One pixel per clock sustained while m_tready is high, cfg_valid low. A result
// passes stage 1 and the window register to m_tdata; border pixels produce none.
// Pipeline: accept + line store read, window shift, kernels into output register.
// Stalls on m_tready back up stage by stage; s_tready drops only when every stage
// holds an item, and while a config write is offered.
// Reset and a config write restart the frame at row 0, column 0.
// Line stores need no clearing: only entries written earlier in the frame are used.
module bayer_demosaic_5x5_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // raw_pixel [15:0]
    input  logic [bdm_pkg::PIX_W-1:0]         s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // red [15:0], green [31:16], blue [47:32]
    output logic [bdm_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                              m_tlast,
    // frame_end [0]
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [bdm_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);

    // frame geometry and position of the next sample
    bdm_pkg::pos_t size_m1_reg, size_m1_next;
    bdm_pkg::pos_t col_reg, col_next;
    bdm_pkg::pos_t row_reg, row_next;
    logic [bdm_pkg::SLOT_W-1:0] lp;

    logic in_req, cfg_req;
    logic s1_move, s1_free, s2_move, s2_free, out_free, out_load;

    // stage 1: accepted sample, line store read in flight
    logic                       v1_reg, v1_next;
    bdm_pkg::pix_t              px1_reg;
    logic [bdm_pkg::SLOT_W-1:0] lp1_reg;
    logic                       emit1_reg, last1_reg, fend1_reg;
    bdm_pkg::site_t             site1_reg;

    // stage 2: window holds the 5x5 neighbourhood
    logic           v2_reg, v2_next;
    bdm_pkg::win_t  win_reg, win_next;
    logic           emit2_reg, last2_reg, fend2_reg;
    bdm_pkg::site_t site2_reg;

    // output register
    logic           m_valid_reg, m_valid_next;
    bdm_pkg::pix_t  red_reg, green_reg, blue_reg;
    logic           last_reg, fend_reg;
    bdm_pkg::pix_t  red_c, green_c, blue_c;

    bdm_pkg::pix_t  ram_rd [bdm_pkg::LINE_SLOTS];

    assign lp = row_reg[bdm_pkg::SLOT_W-1:0];

    // ---------------- handshake and stage advance ----------------
    assign out_free = !m_valid_reg || m_tready;
    assign s2_move  = v2_reg && (!emit2_reg || out_free);
    assign s2_free  = !v2_reg || s2_move;
    assign s1_move  = v1_reg && s2_free;
    assign s1_free  = !v1_reg || s1_move;
    // a config write wins; no pixel request is taken in the same cycle
    assign s_tready = s1_free && !cfg_valid;
    assign in_req   = s_tvalid && s_tready;
    assign out_load = s2_move && emit2_reg;

    assign cfg_ready = 1'b1;
    assign cfg_req   = cfg_valid;

    // ---------------- size register and counters ----------------
    always_comb begin
        size_m1_next = size_m1_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        if (cfg_req) begin
            if (int'(cfg_data) < bdm_pkg::SIZE_MIN) begin
                size_m1_next = bdm_pkg::pos_t'(bdm_pkg::SIZE_MIN - 1);
            end else if (int'(cfg_data) > bdm_pkg::MAX_COLS) begin
                size_m1_next = bdm_pkg::pos_t'(bdm_pkg::MAX_COLS - 1);
            end else begin
                size_m1_next = bdm_pkg::pos_t'(int'(cfg_data) - 1);
            end
            col_next = '0;
            row_next = '0;
        end else if (in_req) begin
            if (col_reg == size_m1_reg) begin
                col_next = '0;
                row_next = (row_reg == size_m1_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // ---------------- line stores: one RAM per slot ----------------
    for (genvar k = 0; k < bdm_pkg::LINE_SLOTS; k++) begin : g_line
        bdm_ram #(
            .WIDTH (bdm_pkg::PIX_W),
            .DEPTH (bdm_pkg::MAX_COLS)
        ) u_line (
            .aclk  (aclk),
            .we    (in_req && (lp == bdm_pkg::SLOT_W'(k))),
            .waddr (col_reg),
            .wdata (s_tdata),
            .re    (in_req),
            .raddr (col_reg),
            .rdata (ram_rd[k])
        );
    end

    // ---------------- window shift ----------------
    always_comb begin
        win_next = win_reg;
        if (s1_move) begin
            for (int i = 0; i < bdm_pkg::WINDOW_LINES; i++) begin
                for (int j = 0; j < bdm_pkg::WINDOW_LINES - 1; j++) begin
                    win_next[i][j] = win_reg[i][j+1];
                end
            end
            // oldest row on top: slot lp holds the row four lines up
            for (int i = 0; i < bdm_pkg::LINE_SLOTS; i++) begin
                win_next[i][bdm_pkg::WINDOW_LINES-1] =
                    ram_rd[bdm_pkg::SLOT_W'(lp1_reg + bdm_pkg::SLOT_W'(i))];
            end
            win_next[bdm_pkg::WINDOW_LINES-1][bdm_pkg::WINDOW_LINES-1] = px1_reg;
        end
    end

    // ---------------- valid bits ----------------
    always_comb begin
        v1_next = v1_reg;
        if (in_req) begin
            v1_next = 1'b1;
        end else if (s1_move) begin
            v1_next = 1'b0;
        end

        v2_next = v2_reg;
        if (s1_move) begin
            v2_next = 1'b1;
        end else if (s2_move) begin
            v2_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    bdm_kernel u_kernel (
        .win   (win_reg),
        .site  (site2_reg),
        .red   (red_c),
        .green (green_c),
        .blue  (blue_c)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_m1_reg <= bdm_pkg::pos_t'(bdm_pkg::SIZE_RESET - 1);
            col_reg     <= '0;
            row_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            size_m1_reg <= size_m1_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_req) begin
            px1_reg           <= s_tdata;
            lp1_reg           <= lp;
            emit1_reg         <= (int'(row_reg) >= bdm_pkg::FIRST_EMIT)
                              && (int'(col_reg) >= bdm_pkg::FIRST_EMIT);
            last1_reg         <= (col_reg == size_m1_reg);
            fend1_reg         <= (col_reg == size_m1_reg) && (row_reg == size_m1_reg);
            site1_reg.row_odd <= row_reg[0];
            site1_reg.col_odd <= col_reg[0];
        end
        win_reg <= win_next;
        if (s1_move) begin
            emit2_reg <= emit1_reg;
            last2_reg <= last1_reg;
            fend2_reg <= fend1_reg;
            site2_reg <= site1_reg;
        end
        if (out_load) begin
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
            last_reg  <= last2_reg;
            fend_reg  <= fend2_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = fend_reg;

    // ---------------- assertions ----------------
    a_fend_is_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && fend_reg |-> last_reg)
        else $error("frame end without row end");

    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= size_m1_reg)
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= size_m1_reg)
        else $error("row counter beyond frame height");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> (col_reg == '0) && (row_reg == '0))
        else $error("config write did not restart the frame");

endmodule
